[rtl/core/upd_pkg.sv]
package upd_pkg;

	// Character codes that the decoder recognizes or produces.
	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// Depth of the queue between the front and the back; a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One queue entry: a single result, or a pair whose second byte is always last.
	typedef struct packed {
		logic       pair;
		logic [7:0] byte0;
		logic       last0;
		logic [7:0] byte1;
	} entry_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Digit value of a character: a decimal digit gives its own value, a letter of
	// either case counts on from ten, and any other character gives zero.
	function automatic logic [5:0] digit_value(input logic [7:0] c);
		logic [7:0] tmp;
		begin
			tmp = 8'd0;
			if (c inside {[8'h41:8'h5A]}) begin
				tmp = c - 8'd55;
			end else if (c inside {[8'h61:8'h7A]}) begin
				tmp = c - 8'd87;
			end else if (c inside {[8'h30:8'h39]}) begin
				tmp = c - 8'd48;
			end
			return tmp[5:0];
		end
	endfunction

endpackage

[rtl/core/upd_front.sv]
module upd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              push,
	output logic              full,
	input  upd_pkg::qstat_t   qstat,
	output logic              wr_en,
	output upd_pkg::entry_t   wr_entry
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PCT  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	logic [1:0] phase_q;
	logic [1:0] phase_d;
	logic [3:0] high_q;
	logic [3:0] high_d;
	logic       accept;
	logic       has_result;
	logic [5:0] dval;
	logic [7:0] plain_byte;

	assign full       = qstat.full;
	assign accept     = push && !qstat.full;
	assign dval       = upd_pkg::digit_value(in_byte);
	assign plain_byte = (in_byte == upd_pkg::PLUS_CHAR) ? upd_pkg::SPACE_CHAR : in_byte;

	// Classify the incoming byte against the escape phase.
	always_comb begin
		phase_d        = PH_IDLE;
		high_d         = high_q;
		has_result     = 1'b1;
		wr_entry.pair  = 1'b0;
		wr_entry.byte0 = plain_byte;
		wr_entry.last0 = in_last;
		wr_entry.byte1 = plain_byte;
		case (phase_q)
			PH_PCT: begin
				if (!in_last) begin
					high_d     = dval[3:0];
					phase_d    = PH_HIGH;
					has_result = 1'b0;
				end else begin
					wr_entry.pair  = 1'b1;
					wr_entry.byte0 = upd_pkg::PCT_CHAR;
					wr_entry.last0 = 1'b0;
				end
			end
			PH_HIGH: begin
				wr_entry.byte0 = {high_q, 4'h0} + {2'b00, dval};
			end
			default: begin
				if (in_byte == upd_pkg::PCT_CHAR && !in_last) begin
					phase_d    = PH_PCT;
					has_result = 1'b0;
				end
			end
		endcase
	end

	assign wr_en = accept && has_result;

	// Escape state advances on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			high_q  <= 4'h0;
		end else if (accept) begin
			phase_q <= phase_d;
			high_q  <= high_d;
		end
	end

endmodule

[rtl/core/upd_queue.sv]
module upd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  upd_pkg::entry_t wr_entry,
	input  logic            rd_en,
	output upd_pkg::entry_t rd_entry,
	output upd_pkg::qstat_t qstat
);

	upd_pkg::entry_t                 mem_q [upd_pkg::QUEUE_DEPTH];
	logic [upd_pkg::QPTR_W-1:0]      wptr_q;
	logic [upd_pkg::QPTR_W-1:0]      rptr_q;
	logic [upd_pkg::QCNT_W-1:0]      count_q;
	logic                            do_wr;
	logic                            do_rd;

	assign qstat.full  = (count_q == upd_pkg::QCNT_W'(upd_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_wr       = wr_en && !qstat.full;
	assign do_rd       = rd_en && !qstat.empty;
	assign rd_entry    = mem_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/upd_back.sv]
module upd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  upd_pkg::entry_t rd_entry,
	input  upd_pkg::qstat_t qstat,
	output logic            rd_en,
	output logic [7:0]      out_byte,
	output logic            out_last,
	output logic            empty,
	input  logic            pop
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       sec_valid_q;
	logic [7:0] sec_byte_q;
	logic       pop_acc;
	logic       room;

	assign pop_acc  = pop && out_valid_q;
	assign room     = !out_valid_q || pop_acc;
	assign rd_en    = room && !sec_valid_q && !qstat.empty;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
	assign empty    = !out_valid_q;

	// Output register, fed by the pending second byte before the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else begin
			if (sec_valid_q && room) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else if (rd_en) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= rd_entry.pair;
			end else if (pop_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (sec_valid_q && room) begin
			out_byte_q <= sec_byte_q;
			out_last_q <= 1'b1;
		end else if (rd_en) begin
			out_byte_q <= rd_entry.byte0;
			out_last_q <= rd_entry.last0;
			sec_byte_q <= rd_entry.byte1;
		end
	end

endmodule

[rtl/core/url_percent_decoder_unit.sv]
// Channel  | Ports                     | Transfer when
// ---------+---------------------------+--------------------------
// input    | in_byte, in_last, push    | push high and full low
//          | full                      |
// result   | out_byte, out_last, empty | pop high and empty low
//          | pop                       |
//
// One input byte is taken every cycle while full is low; a result goes into the queue
// when the byte that completes it is taken, then moves to the output register.
// A string that ends one byte after a '%' gives two results, which leave the output
// register one after the other; a four-entry queue between the classifier and the
// output stage absorbs this and any stall on pop, and full rises only when it fills.
// Reset clears the escape state, the queue and the output register; empty is high.
module url_percent_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       push,
	output logic       full,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       empty,
	input  logic       pop
);

	upd_pkg::qstat_t qstat;
	upd_pkg::entry_t wr_entry;
	upd_pkg::entry_t rd_entry;
	logic            wr_en;
	logic            rd_en;

	// Classifier with escape state.
	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.push     (push),
		.full     (full),
		.qstat    (qstat),
		.wr_en    (wr_en),
		.wr_entry (wr_entry)
	);

	// Decoupling queue.
	upd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_entry (rd_entry),
		.qstat    (qstat)
	);

	// Result sequencer and output register.
	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_entry (rd_entry),
		.qstat    (qstat),
		.rd_en    (rd_en),
		.out_byte (out_byte),
		.out_last (out_last),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

[rtl/core/upd_checker.sv]
module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       empty,
	input logic       pop
);

	// Nothing waits at the output right after reset.
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result shown right after reset");

	// The queue starts with room right after reset.
	a_reset_room: assert property (@(posedge clk) $rose(arst_n) |-> !full)
		else $error("full right after reset");

	// The queue fills only through an input transfer.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	// A waiting result that is not taken stays as it is.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
		else $error("waiting result changed");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.out_byte (out_byte),
	.out_last (out_last),
	.empty    (empty),
	.pop      (pop)
);

[bench/url_percent_decoder_unit_tb.sv]
`timescale 1ns / 100ps

module url_percent_decoder_unit_tb;

	localparam int HOLD_LEN       = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int SHOWN_ERRORS   = 10;

	// Escape tracking of the decoder as seen from outside.
	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_PCT,
		ESC_HIGH
	} esc_state_t;

	// One decoded character with its end-of-string flag.
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} dec_char_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic [7:0] in_byte  = 8'h00;
	logic       in_last  = 1'b0;
	logic       push     = 1'b0;
	logic       pop      = 1'b0;
	logic       full;
	logic [7:0] out_byte;
	logic       out_last;
	logic       empty;

	dec_char_t  expected_chars[$];
	logic [7:0] str_buf[$];
	esc_state_t esc_state   = ESC_IDLE;
	logic [3:0] held_nibble = 4'h0;

	int error_count   = 0;
	int items_sent    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	url_percent_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.push     (push),
		.full     (full),
		.out_byte (out_byte),
		.out_last (out_last),
		.empty    (empty),
		.pop      (pop)
	);

	// Free-running clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Weight of an escape digit: 0-9, letters of either case 10-35, anything else 0.
	function automatic logic [5:0] char_weight(input logic [7:0] c);
		logic [7:0] w;
		w = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			w = c - 8'h41 + 8'd10;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			w = c - 8'h61 + 8'd10;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			w = c - 8'h30;
		end
		return w[5:0];
	endfunction

	// Push a decoded character onto the expected queue.
	task automatic expect_char(input logic [7:0] c, input logic fin);
		dec_char_t d;
		d.ch  = c;
		d.fin = fin;
		expected_chars.push_back(d);
	endtask

	// Update the escape state for one accepted byte and queue what it decodes to.
	task automatic predict_decode(input logic [7:0] c, input logic fin);
		logic [5:0] w;
		logic [7:0] v;
		w = char_weight(c);
		case (esc_state)
			ESC_PCT: begin
				if (!fin) begin
					held_nibble = w[3:0];
					esc_state   = ESC_HIGH;
				end else begin
					// The string ended right after the held percent sign.
					expect_char(upd_pkg::PCT_CHAR, 1'b0);
					expect_char((c == upd_pkg::PLUS_CHAR) ? upd_pkg::SPACE_CHAR : c, 1'b1);
					esc_state = ESC_IDLE;
				end
			end
			ESC_HIGH: begin
				v = {held_nibble, 4'h0} + {2'b00, w};
				expect_char(v, fin);
				esc_state = ESC_IDLE;
			end
			default: begin
				esc_state = ESC_IDLE;
				if (c == upd_pkg::PLUS_CHAR) begin
					expect_char(upd_pkg::SPACE_CHAR, fin);
				end else if (c == upd_pkg::PCT_CHAR && !fin) begin
					esc_state = ESC_PCT;
				end else begin
					expect_char(c, fin);
				end
			end
		endcase
	endtask

	// Offer one byte, with random idle cycles first, and wait for its transfer.
	task automatic send_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		in_byte <= c;
		in_last <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_decode(c, fin);
		items_sent++;
	endtask

	// Send the string in the buffer, flagging its final byte.
	task automatic send_buffer();
		for (int i = 0; i < str_buf.size(); i++) begin
			send_char(str_buf[i], i == str_buf.size() - 1);
		end
	endtask

	// Stop offering and wait until every expected character has come out.
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A character that is usually a valid digit but sometimes any byte.
	function automatic logic [7:0] random_digit_char();
		case ($urandom_range(3))
			0: return 8'h30 + 8'($urandom_range(9));
			1: return 8'h41 + 8'($urandom_range(25));
			2: return 8'h61 + 8'($urandom_range(25));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Build a random string of the given length, mostly made of escapes.
	task automatic build_string(input int len);
		str_buf.delete();
		while (str_buf.size() < len) begin
			case ($urandom_range(9))
				0, 1, 2: str_buf.push_back(8'($urandom_range(255)));
				3: str_buf.push_back(upd_pkg::PLUS_CHAR);
				4: str_buf.push_back(upd_pkg::PCT_CHAR);
				default: begin
					str_buf.push_back(upd_pkg::PCT_CHAR);
					str_buf.push_back(random_digit_char());
					str_buf.push_back(random_digit_char());
				end
			endcase
		end
		// Cutting the tail leaves truncated escapes at the end of some strings.
		while (str_buf.size() > len) void'(str_buf.pop_back());
	endtask

	// Field extremes, every kind of byte and each truncated escape.
	task automatic test_directed_cases();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(upd_pkg::PLUS_CHAR, 1'b1);
		send_char(upd_pkg::PCT_CHAR, 1'b0);
		send_char(8'h34, 1'b0);
		send_char(8'h31, 1'b0);
		send_char(upd_pkg::PCT_CHAR, 1'b0);
		send_char(8'h7A, 1'b0);
		send_char(8'h5A, 1'b0);
		send_char(upd_pkg::PCT_CHAR, 1'b0);
		send_char(8'h66, 1'b0);
		send_char(8'h66, 1'b1);
		send_char(upd_pkg::PCT_CHAR, 1'b0);
		send_char(8'h39, 1'b0);
		send_char(8'h21, 1'b1);
		// A string that ends on a percent sign.
		send_char(upd_pkg::PCT_CHAR, 1'b1);
		// Strings that end one byte after a percent sign.
		send_char(upd_pkg::PCT_CHAR, 1'b0);
		send_char(upd_pkg::PLUS_CHAR, 1'b1);
		send_char(upd_pkg::PCT_CHAR, 1'b0);
		send_char(upd_pkg::PCT_CHAR, 1'b1);
		// Escape whose digits are a percent sign and a plus sign.
		send_char(upd_pkg::PCT_CHAR, 1'b0);
		send_char(upd_pkg::PCT_CHAR, 1'b0);
		send_char(upd_pkg::PLUS_CHAR, 1'b1);
	endtask

	// Random strings, mostly short, until the given number of bytes has gone in.
	task automatic test_random_strings(input int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if ($urandom_range(9) == 0) begin
				build_string($urandom_range(24, 11));
			end else begin
				build_string($urandom_range(10, 1));
			end
			send_buffer();
		end
	endtask

	// The receiver holds off for a long stretch while bytes keep coming.
	task automatic test_receiver_hold();
		hold_req++;
		build_string(60);
		send_buffer();
	endtask

	// The sender pauses until every expected character has come out.
	task automatic test_sender_pause();
		build_string(12);
		send_buffer();
		wait_drained();
		build_string(12);
		send_buffer();
	endtask

	// Compare one transfer on the result side with the oldest expectation.
	task automatic check_result(input logic [7:0] got_ch, input logic got_fin);
		dec_char_t want;
		if (expected_chars.size() == 0) begin
			error_count++;
			if (error_count <= SHOWN_ERRORS) begin
				$display("Unexpected output: byte %h last %b", got_ch, got_fin);
			end
		end else begin
			want = expected_chars.pop_front();
			if (got_ch !== want.ch || got_fin !== want.fin) begin
				error_count++;
				if (error_count <= SHOWN_ERRORS) begin
					$display("Mismatch: expected byte %h last %b, got byte %h last %b",
						want.ch, want.fin, got_ch, got_fin);
				end
			end
		end
	endtask

	// Result side: check each transfer, then choose pop for the next cycle.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			check_result(out_byte, out_last);
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// End the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL url_percent_decoder_unit");
			$finish;
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 68;
		test_directed_cases();
		test_random_strings(500);

		send_idle_pct = 68;
		recv_idle_pct = 22;
		test_random_strings(500);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_receiver_hold();
		test_sender_pause();
		test_random_strings(500);

		wait_drained();
		if (error_count == 0) begin
			$display("PASS url_percent_decoder_unit");
		end else begin
			$display("FAIL url_percent_decoder_unit");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/upd_pkg.sv
rtl/core/upd_front.sv
rtl/core/upd_queue.sv
rtl/core/upd_back.sv
rtl/core/url_percent_decoder_unit.sv
rtl/core/upd_checker.sv
bench/url_percent_decoder_unit_tb.sv
